// ===== rtl/iow_pkg.sv =====
// Shared constants, types and helpers for the in-order instruction window.
package iow_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int RETIRE_WIDTH = 4;
    localparam int ADDR_W       = 48;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int RET_W        = $clog2(RETIRE_WIDTH + 1);
    localparam int BOB_W        = 4;
    localparam int BOB_RESET    = 6;
    localparam int RC_W         = 3;
    localparam int MARK_W       = 8;
    localparam int OCC_W        = 8;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_TICK   = 2'd1,
        K_RESP   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EK_BUBBLE = 2'd0,
        EK_READ   = 2'd1,
        EK_WRITE  = 2'd2,
        EK_OTHER  = 2'd3
    } t_ekind;

    typedef struct packed {
        logic              ready;
        logic              sent;
        logic              wr;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              accepted;
        logic              issue_valid;
        logic [ADDR_W-1:0] issue_addr;
        logic              issue_write;
        logic [RC_W-1:0]   retired_count;
        logic [MARK_W-1:0] marked_count;
        logic [OCC_W-1:0]  occupancy;
        logic              full_res;
        logic              empty_res;
        logic              last;
    } t_result;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
        next_idx = (p == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

endpackage

// ===== rtl/in_order_instruction_window.sv =====
// Top level of the in-order instruction window: config, entry RAM, sequencer, result register.
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_ready    i_kind, i_ready_now, i_entry_addr,
//                                                  i_entry_kind, i_resp_addr
//  out       result     o_out_valid / i_out_ready  o_accepted .. o_last
//  cfg       write      i_cfg_we                   i_cfg_wdata (block offset bits)
//
// One request at a time. Insert and unknown kinds go through S_FIN to the result register.
// Tick: each entry examined is read (S_TRD) and checked (S_TCHK), up to RETIRE_WIDTH
// entries; the walk stops early on a not-ready entry and then goes to S_FIN. Response:
// one RAM read per held entry (none on an empty window), then S_FIN.
// A full result register stalls the sequencer; the next request is taken once the
// last result is in the register. Synchronous reset empties the window; no RAM clear.
module in_order_instruction_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic                       i_ready_now,
    input  logic [iow_pkg::ADDR_W-1:0] i_entry_addr,
    input  logic [1:0]                 i_entry_kind,
    input  logic [iow_pkg::ADDR_W-1:0] i_resp_addr,
    input  logic                       i_cfg_we,
    input  logic [iow_pkg::BOB_W-1:0]  i_cfg_wdata,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_accepted,
    output logic                       o_issue_valid,
    output logic [iow_pkg::ADDR_W-1:0] o_issue_addr,
    output logic                       o_issue_write,
    output logic [iow_pkg::RC_W-1:0]   o_retired_count,
    output logic [iow_pkg::MARK_W-1:0] o_marked_count,
    output logic [iow_pkg::OCC_W-1:0]  o_occupancy,
    output logic                       o_full_res,
    output logic                       o_empty_res,
    output logic                       o_last
);
    import iow_pkg::*;

    logic [BOB_W-1:0]  r_bob;
    logic [ADDR_W-1:0] mask;
    t_ram_req          ram_req;
    logic [ENTRY_W-1:0] rdata_raw;
    t_entry            rdata;
    logic              out_free;
    logic              push;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bob <= BOB_W'(BOB_RESET);
        end else if (i_cfg_we) begin
            r_bob <= i_cfg_wdata;
        end
    end

    assign mask = {ADDR_W{1'b1}} << r_bob;

    iow_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata_raw)
    );

    assign rdata = t_entry'(rdata_raw);

    iow_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_ready_now  (i_ready_now),
        .i_entry_addr (i_entry_addr),
        .i_entry_kind (i_entry_kind),
        .i_resp_addr  (i_resp_addr),
        .i_mask       (mask),
        .i_rdata      (rdata),
        .o_ram        (ram_req),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_res        (res)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out.accepted;
    assign o_issue_valid   = r_out.issue_valid;
    assign o_issue_addr    = r_out.issue_addr;
    assign o_issue_write   = r_out.issue_write;
    assign o_retired_count = r_out.retired_count;
    assign o_marked_count  = r_out.marked_count;
    assign o_occupancy     = r_out.occupancy;
    assign o_full_res      = r_out.full_res;
    assign o_empty_res     = r_out.empty_res;
    assign o_last          = r_out.last;
endmodule

// ===== rtl/iow_ram.sv =====
// Simple dual-port synchronous RAM, registered read data held between reads.
module iow_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 51
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/iow_seq.sv =====
// Sequencer: insert, tick walk and response sweep over the entry RAM.
module iow_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_kind,
    input  logic                      i_ready_now,
    input  logic [iow_pkg::ADDR_W-1:0] i_entry_addr,
    input  logic [1:0]                i_entry_kind,
    input  logic [iow_pkg::ADDR_W-1:0] i_resp_addr,
    input  logic [iow_pkg::ADDR_W-1:0] i_mask,
    input  iow_pkg::t_entry           i_rdata,
    output iow_pkg::t_ram_req         o_ram,
    input  logic                      i_out_free,
    output logic                      o_push,
    output iow_pkg::t_result          o_res
);
    import iow_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TRD  = 5'b00010,
        S_TCHK = 5'b00100,
        S_RSP  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_addr, n_pend_addr;
    logic              r_acc, n_acc;
    logic [RET_W-1:0]  r_retired, n_retired;
    logic [CNT_W-1:0]  r_marked, n_marked;
    logic [ADDR_W-1:0] r_resp, n_resp;

    logic              accept;
    logic [CNT_W:0]    sweep_sum;
    logic [IDX_W-1:0]  sweep_addr;
    logic              hit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Slot of the sweep position, wrapped round the window.
    assign sweep_sum  = (CNT_W+1)'(r_tail) + (CNT_W+1)'(r_idx);
    assign sweep_addr = (sweep_sum >= (CNT_W+1)'(WINDOW_DEPTH))
                      ? IDX_W'(sweep_sum - (CNT_W+1)'(WINDOW_DEPTH))
                      : IDX_W'(sweep_sum);

    assign hit = i_rdata.sent && !i_rdata.ready
              && (((i_rdata.addr ^ r_resp) & i_mask) == '0);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_acc       = r_acc;
        n_retired   = r_retired;
        n_marked    = r_marked;
        n_resp      = r_resp;
        o_ram       = '0;
        o_push      = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_acc     = 1'b0;
                    n_retired = '0;
                    n_marked  = '0;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_resp    = i_resp_addr;
                    n_state   = S_FIN;
                    case (t_kind'(i_kind))
                        K_INSERT: begin
                            if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                                o_ram.we          = 1'b1;
                                o_ram.waddr       = r_head;
                                o_ram.wdata.ready = i_ready_now;
                                o_ram.wdata.sent  = (t_ekind'(i_entry_kind) == EK_BUBBLE);
                                o_ram.wdata.wr    = i_entry_kind[1];
                                o_ram.wdata.addr  = i_entry_addr;
                                n_head            = next_idx(r_head);
                                n_fill            = r_fill + CNT_W'(1);
                                n_acc             = 1'b1;
                            end
                        end
                        K_TICK:  n_state = S_TRD;
                        K_RESP:  n_state = S_RSP;
                        default: n_state = S_FIN;
                    endcase
                end
            end

            S_TRD: begin
                if (r_fill != '0 && r_retired < RET_W'(RETIRE_WIDTH)) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_tail;
                    n_state     = S_TCHK;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_TCHK: begin
                // an unsent entry at the tail goes out first; wait for room
                if (i_rdata.sent || i_out_free) begin
                    if (!i_rdata.sent) begin
                        o_push            = 1'b1;
                        o_res.issue_valid = 1'b1;
                        o_res.issue_addr  = i_rdata.addr;
                        o_res.issue_write = i_rdata.wr;
                        o_res.occupancy   = OCC_W'(r_fill);
                        o_res.full_res    = (r_fill == CNT_W'(WINDOW_DEPTH));
                        o_res.empty_res   = (r_fill == '0);
                        o_ram.we          = 1'b1;
                        o_ram.waddr       = r_tail;
                        o_ram.wdata       = i_rdata;
                        o_ram.wdata.sent  = 1'b1;
                    end
                    if (i_rdata.ready) begin
                        n_tail    = next_idx(r_tail);
                        n_fill    = r_fill - CNT_W'(1);
                        n_retired = r_retired + RET_W'(1);
                        n_state   = S_TRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_RSP: begin
                // read one slot a cycle, check the previous read and mark it on a hit
                if (r_pend && hit) begin
                    o_ram.we          = 1'b1;
                    o_ram.waddr       = r_pend_addr;
                    o_ram.wdata       = i_rdata;
                    o_ram.wdata.ready = 1'b1;
                    n_marked          = r_marked + CNT_W'(1);
                end
                if (r_idx < r_fill) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = sweep_addr;
                    n_pend      = 1'b1;
                    n_pend_addr = sweep_addr;
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (i_out_free) begin
                    o_push              = 1'b1;
                    o_res.accepted      = r_acc;
                    o_res.retired_count = RC_W'(r_retired);
                    o_res.marked_count  = MARK_W'(r_marked);
                    o_res.occupancy     = OCC_W'(r_fill);
                    o_res.full_res      = (r_fill == CNT_W'(WINDOW_DEPTH));
                    o_res.empty_res     = (r_fill == '0);
                    o_res.last          = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_acc       <= n_acc;
        r_retired   <= n_retired;
        r_marked    <= n_marked;
        r_resp      <= n_resp;
    end
endmodule

// ===== rtl/iow_checker.sv =====
// Port-level checks for the in-order instruction window, bound to the top level.
module iow_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_accepted,
    input logic                       o_issue_valid,
    input logic [iow_pkg::ADDR_W-1:0] o_issue_addr,
    input logic                       o_full_res,
    input logic                       o_empty_res,
    input logic                       o_last
);
    import iow_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_issue_addr) && $stable(o_last))
        else $error("result changed while stalled");

    a_issue_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_issue_valid |-> !o_last && !o_accepted)
        else $error("issue result marked last or accepted");

    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("new request taken before last result of previous one");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_full_res && o_empty_res))
        else $error("window reported both full and empty");

    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> !o_empty_res && o_last)
        else $error("accepted insert left the window empty");
endmodule

bind in_order_instruction_window iow_checker u_iow_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_accepted    (o_accepted),
    .o_issue_valid (o_issue_valid),
    .o_issue_addr  (o_issue_addr),
    .o_full_res    (o_full_res),
    .o_empty_res   (o_empty_res),
    .o_last        (o_last)
);

// ===== test/window_monitor.sv =====
// Channel monitor for the instruction window: predicts each request's results and checks them.
module window_monitor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_kind,
    input  logic                       i_ready_now,
    input  logic [iow_pkg::ADDR_W-1:0] i_entry_addr,
    input  logic [1:0]                 i_entry_kind,
    input  logic [iow_pkg::ADDR_W-1:0] i_resp_addr,
    input  logic                       i_cfg_we,
    input  logic [iow_pkg::BOB_W-1:0]  i_cfg_wdata,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_accepted,
    input  logic                       i_issue_valid,
    input  logic [iow_pkg::ADDR_W-1:0] i_issue_addr,
    input  logic                       i_issue_write,
    input  logic [iow_pkg::RC_W-1:0]   i_retired_count,
    input  logic [iow_pkg::MARK_W-1:0] i_marked_count,
    input  logic [iow_pkg::OCC_W-1:0]  i_occupancy,
    input  logic                       i_full_res,
    input  logic                       i_empty_res,
    input  logic                       i_last,
    output int                         o_pending,
    output int                         o_fail_total,
    output int                         o_results_seen,
    output int                         o_issues_seen,
    output int                         o_refused_seen,
    output int                         o_marked_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import iow_pkg::*;

    localparam int PRINT_CAP = 25;

    logic              win_ready [WINDOW_DEPTH];
    logic              win_sent  [WINDOW_DEPTH];
    logic              win_write [WINDOW_DEPTH];
    logic [ADDR_W-1:0] win_addr  [WINDOW_DEPTH];
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [CNT_W-1:0]  held;
    logic [BOB_W-1:0]  offset_bits;
    t_result           due_results [$];

    initial begin
        o_pending      = 0;
        o_fail_total   = 0;
        o_results_seen = 0;
        o_issues_seen  = 0;
        o_refused_seen = 0;
        o_marked_seen  = 0;
    end

    // Status fields always reflect the window after the step so far.
    function automatic t_result window_status(input logic acc, input logic iv,
                                              input logic [ADDR_W-1:0] ia, input logic iw,
                                              input logic [RC_W-1:0] rc,
                                              input logic [MARK_W-1:0] mc, input logic fin);
        t_result r;
        r.accepted      = acc;
        r.issue_valid   = iv;
        r.issue_addr    = ia;
        r.issue_write   = iw;
        r.retired_count = rc;
        r.marked_count  = mc;
        r.occupancy     = OCC_W'(held);
        r.full_res      = (held == WINDOW_DEPTH);
        r.empty_res     = (held == 0);
        r.last          = fin;
        return r;
    endfunction

    task automatic add_due(input t_result r);
        due_results.insert(due_results.size(), r);
    endtask

    task automatic step_window(input t_kind k, input logic rn, input logic [ADDR_W-1:0] ea,
                               input t_ekind ek, input logic [ADDR_W-1:0] ra);
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] mask;
        int                retired;
        int                marked;
        case (k)
            K_INSERT: begin
                if (held >= WINDOW_DEPTH) begin
                    add_due(window_status(1'b0, 1'b0, '0, 1'b0, '0, '0, 1'b1));
                    o_refused_seen++;
                end else begin
                    win_ready[head_idx] = rn;
                    win_addr[head_idx]  = ea;
                    // the unused fourth kind behaves as a write
                    win_write[head_idx] = (ek == EK_WRITE) || (ek == EK_OTHER);
                    win_sent[head_idx]  = (ek == EK_BUBBLE);
                    head_idx = head_idx + 1'b1;
                    held = held + 1'b1;
                    add_due(window_status(1'b1, 1'b0, '0, 1'b0, '0, '0, 1'b1));
                end
            end
            K_TICK: begin
                retired = 0;
                while (held != 0 && retired < RETIRE_WIDTH) begin
                    if (!win_sent[tail_idx]) begin
                        add_due(window_status(1'b0, 1'b1, win_addr[tail_idx],
                                              win_write[tail_idx], '0, '0, 1'b0));
                        win_sent[tail_idx] = 1'b1;
                        o_issues_seen++;
                    end
                    if (!win_ready[tail_idx])
                        break;
                    win_ready[tail_idx] = 1'b0;
                    win_sent[tail_idx]  = 1'b0;
                    tail_idx = tail_idx + 1'b1;
                    held = held - 1'b1;
                    retired++;
                end
                add_due(window_status(1'b0, 1'b0, '0, 1'b0, RC_W'(retired), '0, 1'b1));
            end
            K_RESP: begin
                mask   = ~((ADDR_W'(1) << offset_bits) - ADDR_W'(1));
                marked = 0;
                for (int i = 0; i < held; i++) begin
                    idx = tail_idx + IDX_W'(i);
                    if (win_sent[idx] && !win_ready[idx] &&
                        ((win_addr[idx] & mask) == (ra & mask))) begin
                        win_ready[idx] = 1'b1;
                        marked++;
                    end
                end
                o_marked_seen += marked;
                add_due(window_status(1'b0, 1'b0, '0, 1'b0, '0, MARK_W'(marked), 1'b1));
            end
            default: begin
                add_due(window_status(1'b0, 1'b0, '0, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (o_fail_total < PRINT_CAP)
            $display("%0t ns result %0d: %s got 0x%0h, predicted 0x%0h",
                     $realtime, o_results_seen, what, got, want);
        o_fail_total++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_ready[i] = 1'b0;
                win_sent[i]  = 1'b0;
                win_write[i] = 1'b0;
                win_addr[i]  = '0;
            end
            head_idx    = '0;
            tail_idx    = '0;
            held        = '0;
            offset_bits = BOB_W'(BOB_RESET);
            due_results.delete();
        end else begin
            if (i_cfg_we)
                offset_bits = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no request outstanding, last", i_last, 0);
                end else begin
                    want = due_results.pop_front();
                    check_field("accepted", i_accepted, want.accepted);
                    check_field("issue_valid", i_issue_valid, want.issue_valid);
                    check_field("issue_addr", i_issue_addr, want.issue_addr);
                    check_field("issue_write", i_issue_write, want.issue_write);
                    check_field("retired_count", i_retired_count, want.retired_count);
                    check_field("marked_count", i_marked_count, want.marked_count);
                    check_field("occupancy", i_occupancy, want.occupancy);
                    check_field("full_res", i_full_res, want.full_res);
                    check_field("empty_res", i_empty_res, want.empty_res);
                    check_field("last", i_last, want.last);
                end
                o_results_seen++;
            end
            if (i_in_valid && i_in_ready)
                step_window(t_kind'(i_kind), i_ready_now, i_entry_addr, t_ekind'(i_entry_kind),
                            i_resp_addr);
        end
        o_pending = due_results.size();
    end

endmodule

// ===== test/in_order_instruction_window_test.sv =====
// Testbench top for the instruction window: clock, reset, request stimulus and verdict.
module in_order_instruction_window_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iow_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;
    localparam int POOL_SIZE     = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_kind;
    logic              i_ready_now;
    logic [ADDR_W-1:0] i_entry_addr;
    logic [1:0]        i_entry_kind;
    logic [ADDR_W-1:0] i_resp_addr;
    logic              i_cfg_we;
    logic [BOB_W-1:0]  i_cfg_wdata;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_accepted;
    logic              o_issue_valid;
    logic [ADDR_W-1:0] o_issue_addr;
    logic              o_issue_write;
    logic [RC_W-1:0]   o_retired_count;
    logic [MARK_W-1:0] o_marked_count;
    logic [OCC_W-1:0]  o_occupancy;
    logic              o_full_res;
    logic              o_empty_res;
    logic              o_last;

    int pending;
    int fail_total;
    int results_seen;
    int issues_seen;
    int refused_seen;
    int marked_seen;

    int                cycle_count = 0;
    int                burst_left  = 0;
    int                kinds_sent [4];
    bit                valid_up     = 1'b0;
    bit                hold_request = 1'b0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    in_order_instruction_window uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_ready_now     (i_ready_now),
        .i_entry_addr    (i_entry_addr),
        .i_entry_kind    (i_entry_kind),
        .i_resp_addr     (i_resp_addr),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_issue_valid   (o_issue_valid),
        .o_issue_addr    (o_issue_addr),
        .o_issue_write   (o_issue_write),
        .o_retired_count (o_retired_count),
        .o_marked_count  (o_marked_count),
        .o_occupancy     (o_occupancy),
        .o_full_res      (o_full_res),
        .o_empty_res     (o_empty_res),
        .o_last          (o_last)
    );

    window_monitor u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_ready_now     (i_ready_now),
        .i_entry_addr    (i_entry_addr),
        .i_entry_kind    (i_entry_kind),
        .i_resp_addr     (i_resp_addr),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_accepted      (o_accepted),
        .i_issue_valid   (o_issue_valid),
        .i_issue_addr    (o_issue_addr),
        .i_issue_write   (o_issue_write),
        .i_retired_count (o_retired_count),
        .i_marked_count  (o_marked_count),
        .i_occupancy     (o_occupancy),
        .i_full_res      (o_full_res),
        .i_empty_res     (o_empty_res),
        .i_last          (o_last),
        .o_pending       (pending),
        .o_fail_total    (fail_total),
        .o_results_seen  (results_seen),
        .o_issues_seen   (issues_seen),
        .o_refused_seen  (refused_seen),
        .o_marked_seen   (marked_seen)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("in_order_instruction_window: mismatch");
            $finish;
        end
    end

    // Result side: random stall density, changed per pattern of random length; a long hold on request.
    initial begin
        int pattern_left;
        int stall_pct;
        i_out_ready  = 1'b0;
        pattern_left = 0;
        stall_pct    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(8, 64);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            pattern_left--;
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Mostly addresses from a small pool so that responses find their entries.
    function automatic logic [ADDR_W-1:0] near_addr();
        logic [ADDR_W-1:0] a;
        a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        case ($urandom_range(0, 9))
            0:       a = any_addr();
            1, 2, 3: a = a ^ ADDR_W'($urandom_range(0, 63));
            4, 5:    a = a ^ ADDR_W'($urandom_range(0, 8191));
            default: ;
        endcase
        return a;
    endfunction

    task automatic offer(input t_kind k, input logic rn, input logic [ADDR_W-1:0] ea,
                         input t_ekind ek, input logic [ADDR_W-1:0] ra);
        i_in_valid   <= 1'b1;
        valid_up      = 1'b1;
        i_kind       <= k;
        i_ready_now  <= rn;
        i_entry_addr <= ea;
        i_entry_kind <= ek;
        i_resp_addr  <= ra;
        do @(posedge i_clk); while (!o_in_ready);
        kinds_sent[k]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            valid_up    = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic settle();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up    = 1'b0;
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_block_offset(input logic [BOB_W-1:0] bits);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bits;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int     pick;
        t_ekind ek;
        pick = $urandom_range(0, 99);
        ek   = t_ekind'($urandom_range(0, 3));
        if (pick < 45)
            offer(K_INSERT, ($urandom_range(0, 2) == 0), near_addr(), ek, any_addr());
        else if (pick < 75)
            offer(K_TICK, $urandom_range(0, 1), any_addr(), ek, any_addr());
        else if (pick < 97)
            offer(K_RESP, $urandom_range(0, 1), any_addr(), ek, near_addr());
        else
            offer(K_NONE, $urandom_range(0, 1), any_addr(), ek, any_addr());
    endtask

    initial begin
        logic [ADDR_W-1:0] dir_addr;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = K_INSERT;
        i_ready_now  = 1'b0;
        i_entry_addr = '0;
        i_entry_kind = EK_BUBBLE;
        i_resp_addr  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        for (int i = 0; i < 4; i++)
            kinds_sent[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = any_addr();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, default block offset of 6 bits.
        dir_addr = any_addr() & ~ADDR_W'(8'hff);
        offer(K_TICK, 1'b1, '1, EK_OTHER, '1);
        offer(K_RESP, 1'b0, '0, EK_BUBBLE, '1);
        offer(K_NONE, 1'b1, any_addr(), EK_WRITE, any_addr());
        offer(K_INSERT, 1'b1, '0, EK_BUBBLE, '0);
        offer(K_INSERT, 1'b0, '1, EK_READ, '0);
        offer(K_INSERT, 1'b0, dir_addr, EK_WRITE, '1);
        offer(K_INSERT, 1'b0, dir_addr | ADDR_W'(6'h3f), EK_OTHER, '0);
        offer(K_INSERT, 1'b1, any_addr(), EK_READ, '0);
        offer(K_INSERT, 1'b1, any_addr(), EK_WRITE, '0);
        offer(K_TICK, 1'b0, '0, EK_BUBBLE, '0);
        offer(K_RESP, 1'b0, '0, EK_BUBBLE, ~ADDR_W'(6'h3f));
        offer(K_TICK, 1'b0, '0, EK_BUBBLE, '0);
        offer(K_RESP, 1'b0, '0, EK_BUBBLE, dir_addr ^ ADDR_W'(8'h40));
        offer(K_RESP, 1'b0, '0, EK_BUBBLE, dir_addr ^ ADDR_W'(6'h15));
        offer(K_TICK, 1'b0, '0, EK_BUBBLE, '0);
        offer(K_RESP, 1'b0, '0, EK_BUBBLE, dir_addr);
        offer(K_TICK, 1'b0, '0, EK_BUBBLE, '0);
        offer(K_TICK, 1'b1, '1, EK_OTHER, '1);
        offer(K_NONE, 1'b0, '0, EK_OTHER, '0);

        // Random part over several block sizes; exact matching first.
        settle();
        set_block_offset(4'd0);
        repeat (27) random_request();
        settle();
        set_block_offset(4'd12);
        // long result stall while requests keep coming
        hold_request = 1'b1;
        repeat (27) random_request();
        settle();
        set_block_offset(BOB_W'($urandom_range(1, 15)));
        repeat (27) random_request();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d inserts, %0d ticks, %0d responses, %0d ignored requests",
                 kinds_sent[K_INSERT], kinds_sent[K_TICK], kinds_sent[K_RESP],
                 kinds_sent[K_NONE]);
        $display("%0d results checked: %0d issues, %0d refused inserts, %0d entries marked",
                 results_seen, issues_seen, refused_seen, marked_seen);
        if (fail_total == 0)
            $display("in_order_instruction_window: match");
        else
            $display("in_order_instruction_window: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/iow_pkg.sv
rtl/iow_ram.sv
rtl/iow_seq.sv
rtl/in_order_instruction_window.sv
rtl/iow_checker.sv
test/window_monitor.sv
test/in_order_instruction_window_test.sv
